// ----- hdl/scpg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package scpg_pkg;

  localparam int ENTRY_DEPTH = 9;
  localparam int LEN_W = $clog2(ENTRY_DEPTH + 1);
  localparam int IDX_W = $clog2(ENTRY_DEPTH);

  // register indexes
  localparam logic CFG_HIGH_TICKS = 1'b0;
  localparam logic CFG_LOW_TICKS  = 1'b1;

  // phase codes
  localparam logic [1:0] PH_HIGH_WAIT = 2'd0;
  localparam logic [1:0] PH_EVAL      = 2'd1;
  localparam logic [1:0] PH_LOW_WAIT  = 2'd2;
  localparam logic [1:0] PH_FALL      = 2'd3;

  // character codes
  localparam logic [7:0] KEY_ETX   = 8'd3;
  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_ESC   = 8'd27;
  localparam logic [7:0] KEY_COLON = 8'h3a;
  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;
  localparam logic [7:0] KEY_PLUS  = 8'h2b;
  localparam logic [7:0] KEY_EQ    = 8'h3d;
  localparam logic [7:0] KEY_MINUS = 8'h2d;
  localparam logic [7:0] KEY_UNDER = 8'h5f;
  localparam logic [7:0] KEY_UZ    = 8'h5a;
  localparam logic [7:0] KEY_LZ    = 8'h7a;
  localparam logic [7:0] KEY_UA    = 8'h41;
  localparam logic [7:0] KEY_LA    = 8'h61;
  localparam logic [7:0] KEY_UB    = 8'h42;
  localparam logic [7:0] KEY_LB    = 8'h62;
  localparam logic [7:0] KEY_UC    = 8'h43;
  localparam logic [7:0] KEY_LC    = 8'h63;

  // buffered code of a colon
  localparam logic [3:0] COLON_CODE = 4'd10;

  typedef struct packed {
    logic load;   // capture accepted word
    logic key;    // tick count / entry buffer update
    logic scan;   // one buffered character parsed
    logic apply;  // parse result and command applied
    logic step;   // one phase transition
    logic emit;   // result register loaded
  } scpg_cmd_t;

  typedef struct packed {
    logic need_parse;
    logic scan_last;
    logic settled;
  } scpg_sts_t;

  // acc*10+d, saturated at 127 (only compared against 59)
  function automatic logic [6:0] sat_acc(input logic [6:0] a, input logic [3:0] d);
    logic [10:0] t;
    t = {4'b0, a} * 11'd10 + {7'b0, d};
    return (t > 11'd127) ? 7'd127 : t[6:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/scpg_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface scpg_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] key_char;
  modport source (output valid, kind, key_char, input ready);
  modport sink (input valid, kind, key_char, output ready);
endinterface

interface scpg_out_if;
  logic       valid;
  logic       ready;
  logic       line_a;
  logic       line_b;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic       time_changed;
  logic       bad_time;
  logic       entry_active;
  modport source (output valid, line_a, line_b, minutes, seconds, time_changed, bad_time,
                  entry_active, input ready);
  modport sink (input valid, line_a, line_b, minutes, seconds, time_changed, bad_time,
                entry_active, output ready);
endinterface
`default_nettype wire

// ----- hdl/slave_clock_pulse_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// slave clock pulse generator: keeps mm:ss and drives slave-clock lines a and b
// in_ch carries one word per event: kind 0 is a 10 ms tick, kind 1 a key char
// out_ch returns one word per input word: line levels, time and entry flags
// cfg port writes high_ticks (index 0) and low_ticks (index 1); the user must
//   write them only while idle, the block itself does not enforce it
// steps: capture, key update, a parse of the buffered characters (up to 9) when
//   a time entry is parsed, command, the phase transitions of the second
//   sequencer, then the output register load; one word at a time, the next word
//   is taken once the result sits in the output register, in the cycle that
//   result is taken
// reset (synchronous, rst_n low): time 00:00, pulse decisions low, registers 6 and 4,
//   entry mode off, output register empty
// a stalled receiver holds the result in the output register and blocks
//   the input channel until the word is taken
module slave_clock_pulse_generator (
  input  wire        clk,
  input  wire        rst_n,
  scpg_in_if.sink    in_ch,
  scpg_out_if.source out_ch,
  input  wire        cfg_we,
  input  wire        cfg_addr,
  input  wire [7:0]  cfg_wdata
);

  scpg_pkg::scpg_cmd_t cmd;
  scpg_pkg::scpg_sts_t sts;

  // sequencing of capture, parse, command and settle steps
  scpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // time keeping, entry buffer, phase sequencer and result register
  scpg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_ch.kind),
    .in_key_char    (in_ch.key_char),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .o_line_a       (out_ch.line_a),
    .o_line_b       (out_ch.line_b),
    .o_minutes      (out_ch.minutes),
    .o_seconds      (out_ch.seconds),
    .o_time_changed (out_ch.time_changed),
    .o_bad_time     (out_ch.bad_time),
    .o_entry_active (out_ch.entry_active)
  );

`ifndef SYNTHESIS
  // an accepted word never has its result ready in the next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !out_ch.valid)
    else $error("result appeared one cycle after accept");

  // kept time stays in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.minutes <= 6'd59) && (out_ch.seconds <= 6'd59))
    else $error("kept time out of range");
`endif

endmodule
`default_nettype wire

// ----- hdl/scpg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module scpg_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  scpg_pkg::scpg_sts_t sts,
  output scpg_pkg::scpg_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_KEY    = 3'd1;
  localparam logic [2:0] S_PARSE  = 3'd2;
  localparam logic [2:0] S_CMD    = 3'd3;
  localparam logic [2:0] S_SETTLE = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && (!valid_r || out_ready);
  assign out_valid = valid_r;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r && !out_ready;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_KEY;
        end
      end
      S_KEY: begin
        cmd.key   = 1'b1;
        state_nxt = sts.need_parse ? S_PARSE : S_CMD;
      end
      S_PARSE: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_CMD;
      end
      S_CMD: begin
        cmd.apply = 1'b1;
        state_nxt = S_SETTLE;
      end
      S_SETTLE: begin
        if (sts.settled) state_nxt = S_OUT;
        else cmd.step = 1'b1;
      end
      S_OUT: begin
        cmd.emit  = 1'b1;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/scpg_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module scpg_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  scpg_pkg::scpg_cmd_t cmd,
  output scpg_pkg::scpg_sts_t sts,
  input  wire                 in_kind,
  input  wire  [7:0]          in_key_char,
  input  wire                 cfg_we,
  input  wire                 cfg_addr,
  input  wire  [7:0]          cfg_wdata,
  output logic                o_line_a,
  output logic                o_line_b,
  output logic [5:0]          o_minutes,
  output logic [5:0]          o_seconds,
  output logic                o_time_changed,
  output logic                o_bad_time,
  output logic                o_entry_active
);

  localparam int LW = scpg_pkg::LEN_W;
  localparam int IW = scpg_pkg::IDX_W;

  logic [7:0]    high_r, low_r;
  logic          kind_r;
  logic [7:0]    char_r;
  logic [5:0]    minute_r, second_r;
  logic [1:0]    phase_r;
  logic [7:0]    tick_r;
  logic          pulse_a_r, pulse_b_r;
  logic [7:0]    force_a_r, force_b_r;
  logic          entry_mode_r;
  logic [3:0]    chars_r [scpg_pkg::ENTRY_DEPTH];
  logic [LW-1:0] len_r;
  logic          changed_r, bad_r, parse_r;
  logic [LW-1:0] idx_r, col_r;
  logic          colon_r, sec_stop_r;
  logic [6:0]    pre_r, hi_r, sec_r;
  logic [3:0]    d1_r, d2_r;
  logic [3:0]    ch_r;

  logic          key_ok, is_entry;
  logic [7:0]    hi_len, lo_len;
  logic [LW-1:0] idx_inc;
  logic          pmv, psv, pbad, pok;
  logic [6:0]    pm, ps;
  logic [5:0]    base_min, new_min, new_sec;
  logic          resync;

  assign key_ok   = kind_r && (char_r != 8'd0) && !char_r[7];
  assign is_entry = ((char_r >= scpg_pkg::KEY_ZERO) && (char_r <= scpg_pkg::KEY_NINE)) ||
                    (char_r == scpg_pkg::KEY_COLON);
  assign hi_len   = (high_r == 8'd0) ? 8'd1 : high_r;
  assign lo_len   = (low_r == 8'd0) ? 8'd1 : low_r;
  assign idx_inc  = idx_r + 1'b1;

  always_comb begin
    sts.need_parse = key_ok && !is_entry && entry_mode_r && (len_r != '0) &&
                     (char_r != scpg_pkg::KEY_ESC) && (char_r != scpg_pkg::KEY_ETX) &&
                     (char_r != scpg_pkg::KEY_BS);
    sts.scan_last  = ({1'b0, idx_r} + 1'b1) == {1'b0, len_r};
    sts.settled    = ((phase_r == scpg_pkg::PH_HIGH_WAIT) && (tick_r < hi_len)) ||
                     ((phase_r == scpg_pkg::PH_LOW_WAIT) && (tick_r < lo_len));
  end

  // parse result
  always_comb begin
    pm  = hi_r;
    ps  = pre_r;
    pmv = 1'b0;
    psv = 1'b1;
    if (colon_r) begin
      pm  = pre_r;
      pmv = (col_r != '0);
      ps  = sec_r;
      psv = ({1'b0, col_r} + 1'b1) < {1'b0, len_r};
    end else if (len_r > LW'(2)) begin
      pmv = 1'b1;
      ps  = {3'b0, d1_r} * 7'd10 + {3'b0, d2_r};
    end
    pbad = parse_r && ((pmv && (pm > 7'd59)) || (psv && (ps > 7'd59)));
    pok  = parse_r && !pbad;
    base_min = (pok && pmv) ? pm[5:0] : minute_r;
    new_sec  = (pok && psv) ? ps[5:0] : second_r;
    resync   = pok && psv;
    new_min  = base_min;
    if (key_ok) begin
      case (char_r)
        scpg_pkg::KEY_PLUS, scpg_pkg::KEY_EQ:
          new_min = (base_min >= 6'd59) ? 6'd0 : base_min + 6'd1;
        scpg_pkg::KEY_MINUS, scpg_pkg::KEY_UNDER:
          new_min = ((base_min == 6'd0) || (base_min > 6'd59)) ? 6'd59 : base_min - 6'd1;
        scpg_pkg::KEY_UZ, scpg_pkg::KEY_LZ: begin
          new_sec = 6'd0;
          resync  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic cmd_changed, frc_a, frc_b;
  always_comb begin
    cmd_changed = 1'b0;
    frc_a = 1'b0;
    frc_b = 1'b0;
    if (key_ok) begin
      case (char_r)
        scpg_pkg::KEY_PLUS, scpg_pkg::KEY_EQ, scpg_pkg::KEY_MINUS, scpg_pkg::KEY_UNDER,
        scpg_pkg::KEY_UZ, scpg_pkg::KEY_LZ: cmd_changed = 1'b1;
        scpg_pkg::KEY_UA, scpg_pkg::KEY_LA: frc_a = 1'b1;
        scpg_pkg::KEY_UB, scpg_pkg::KEY_LB: frc_b = 1'b1;
        scpg_pkg::KEY_UC, scpg_pkg::KEY_LC: begin
          frc_a = 1'b1;
          frc_b = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // pulse decision at the start of a second
  logic dec_a, dec_b;
  always_comb begin
    dec_a = (force_a_r != 8'd0) || (second_r == 6'd0) ||
            ((minute_r == 6'd59) && (second_r >= 6'd10) && (second_r <= 6'd50) &&
             !second_r[0]);
    dec_b = (force_b_r != 8'd0) || ((minute_r <= 6'd49) && (second_r == 6'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r       <= 8'd6;
      low_r        <= 8'd4;
      minute_r     <= '0;
      second_r     <= '0;
      phase_r      <= scpg_pkg::PH_EVAL;
      tick_r       <= '0;
      pulse_a_r    <= 1'b0;
      pulse_b_r    <= 1'b0;
      force_a_r    <= '0;
      force_b_r    <= '0;
      entry_mode_r <= 1'b0;
      len_r        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == scpg_pkg::CFG_HIGH_TICKS) high_r <= cfg_wdata;
        else low_r <= cfg_wdata;
      end
      if (cmd.load) begin
        kind_r    <= in_kind;
        char_r    <= in_key_char;
        changed_r <= 1'b0;
        bad_r     <= 1'b0;
        parse_r   <= 1'b0;
      end
      if (cmd.key) begin
        idx_r      <= '0;
        colon_r    <= 1'b0;
        sec_stop_r <= 1'b0;
        pre_r      <= '0;
        hi_r       <= '0;
        sec_r      <= '0;
        d1_r       <= '0;
        d2_r       <= '0;
        // first buffered character ready for the scan
        ch_r       <= chars_r[IW'(0)];
        parse_r    <= sts.need_parse;
        if (!kind_r) begin
          if (tick_r != 8'hff) tick_r <= tick_r + 8'd1;
        end else if (key_ok && is_entry) begin
          entry_mode_r <= 1'b1;
          if (len_r < LW'(scpg_pkg::ENTRY_DEPTH)) begin
            chars_r[len_r[IW-1:0]] <= (char_r == scpg_pkg::KEY_COLON) ?
                                      scpg_pkg::COLON_CODE : char_r[3:0];
            len_r <= len_r + 1'b1;
          end
        end else if (key_ok && entry_mode_r) begin
          if ((char_r == scpg_pkg::KEY_ESC) || (char_r == scpg_pkg::KEY_ETX)) begin
            len_r        <= '0;
            entry_mode_r <= 1'b0;
          end else if (char_r == scpg_pkg::KEY_BS) begin
            if (len_r != '0) len_r <= len_r - 1'b1;
          end else begin
            entry_mode_r <= 1'b0;
          end
        end
      end
      if (cmd.scan) begin
        idx_r <= idx_inc;
        // fetch the next character for the following scan cycle
        if (!sts.scan_last) ch_r <= chars_r[idx_inc[IW-1:0]];
        if (!colon_r) begin
          if (ch_r == scpg_pkg::COLON_CODE) begin
            colon_r <= 1'b1;
            col_r   <= idx_r;
          end else begin
            pre_r <= scpg_pkg::sat_acc(pre_r, ch_r);
            if (({1'b0, idx_r} + 2'd2) < {1'b0, len_r}) hi_r <= scpg_pkg::sat_acc(hi_r, ch_r);
            d1_r <= d2_r;
            d2_r <= ch_r;
          end
        end else if (!sec_stop_r) begin
          if (ch_r == scpg_pkg::COLON_CODE) sec_stop_r <= 1'b1;
          else sec_r <= scpg_pkg::sat_acc(sec_r, ch_r);
        end
      end
      if (cmd.apply) begin
        if (parse_r) len_r <= '0;
        bad_r     <= pbad;
        changed_r <= pok || cmd_changed;
        minute_r  <= new_min;
        second_r  <= new_sec;
        if (resync) begin
          tick_r  <= '0;
          phase_r <= scpg_pkg::PH_EVAL;
        end
        if (frc_a && (force_a_r != 8'hff)) force_a_r <= force_a_r + 8'd1;
        if (frc_b && (force_b_r != 8'hff)) force_b_r <= force_b_r + 8'd1;
      end
      if (cmd.step) begin
        case (phase_r)
          scpg_pkg::PH_EVAL: begin
            pulse_a_r <= dec_a;
            pulse_b_r <= dec_b;
            if (force_a_r != 8'd0) force_a_r <= force_a_r - 8'd1;
            if (force_b_r != 8'd0) force_b_r <= force_b_r - 8'd1;
            phase_r <= scpg_pkg::PH_HIGH_WAIT;
          end
          scpg_pkg::PH_HIGH_WAIT: begin
            tick_r  <= tick_r - hi_len;
            phase_r <= scpg_pkg::PH_FALL;
          end
          scpg_pkg::PH_FALL: phase_r <= scpg_pkg::PH_LOW_WAIT;
          default: begin
            tick_r  <= tick_r - lo_len;
            phase_r <= scpg_pkg::PH_EVAL;
            if (second_r >= 6'd59) begin
              second_r <= 6'd0;
              minute_r <= (minute_r >= 6'd59) ? 6'd0 : minute_r + 6'd1;
            end else begin
              second_r <= second_r + 6'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_line_a       <= (phase_r == scpg_pkg::PH_HIGH_WAIT) && pulse_a_r;
      o_line_b       <= (phase_r == scpg_pkg::PH_HIGH_WAIT) && pulse_b_r;
      o_minutes      <= minute_r;
      o_seconds      <= second_r;
      o_time_changed <= changed_r;
      o_bad_time     <= bad_r;
      o_entry_active <= entry_mode_r;
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_scpg_ifs.sv -----
`timescale 1ns / 1ps
// the block's channel interfaces live with the rtl; nothing extra is needed here
package tb_scpg_types;
  typedef struct packed {
    logic       line_a;
    logic       line_b;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       time_changed;
    logic       bad_time;
    logic       entry_active;
  } clock_word_t;
endpackage

// ----- sim/tb_slave_clock_pulse_generator.sv -----
`timescale 1ns / 1ps
module tb_slave_clock_pulse_generator;
  import scpg_pkg::*;
  import tb_scpg_types::*;

  // predicts clock lines and kept time from ticks and keys
  class clock_scoreboard;
    int unsigned hi_reg, lo_reg;
    int unsigned mins, secs, ph, ticks, pa, pb, force_a, force_b, buf_len;
    bit entering;
    int unsigned chars[ENTRY_DEPTH];
    clock_word_t pending[$];
    int errors;

    function void reset_state();
      hi_reg = 6; lo_reg = 4; mins = 0; secs = 0; ph = PH_EVAL; ticks = 0;
      pa = 0; pb = 0; force_a = 0; force_b = 0; buf_len = 0; entering = 0;
      pending.delete();
    endfunction

    function void set_reg(logic idx, int unsigned v);
      if (idx == CFG_HIGH_TICKS) hi_reg = v; else lo_reg = v;
    endfunction

    function int unsigned digits(int unsigned from, int unsigned to);
      int unsigned v;
      v = 0;
      for (int unsigned i = from; i < to && chars[i] < 10; i++) begin
        v = v * 10 + chars[i];
        if (v > 999999) v = 999999;
      end
      return v;
    endfunction

    // returns 1 when an entry was accepted
    function bit entry_char(int unsigned c, bit is_digit, ref bit bad);
      int unsigned col;
      int m0, s0;
      m0 = -1; s0 = -1;
      if (is_digit) begin
        if (buf_len < ENTRY_DEPTH) begin
          chars[buf_len] = (c == KEY_COLON) ? COLON_CODE : c - KEY_ZERO;
          buf_len++;
        end
        return 0;
      end
      if (c == KEY_ESC || c == KEY_ETX) begin
        buf_len = 0; entering = 0; return 0;
      end
      if (c == KEY_BS) begin
        if (buf_len > 0) buf_len--;
        return 0;
      end
      entering = 0;
      if (buf_len == 0) return 0;
      for (col = 0; col < buf_len && chars[col] != COLON_CODE; col++) ;
      if (col < buf_len) begin
        if (col > 0) m0 = digits(0, col);
        if (col + 1 < buf_len) s0 = digits(col + 1, buf_len);
      end else begin
        s0 = digits(0, buf_len);
        if (buf_len > 2) begin m0 = s0 / 100; s0 = s0 % 100; end
      end
      buf_len = 0;
      if (m0 > 59 || s0 > 59) begin bad = 1; return 0; end
      if (s0 >= 0) begin ticks = 0; ph = PH_EVAL; end
      if (m0 >= 0) mins = m0;
      if (s0 >= 0) secs = s0;
      return 1;
    endfunction

    function bit command(int unsigned c);
      case (c)
        KEY_PLUS, KEY_EQ: begin mins = (mins >= 59) ? 0 : mins + 1; return 1; end
        KEY_MINUS, KEY_UNDER: begin mins = (mins == 0 || mins > 59) ? 59 : mins - 1; return 1; end
        KEY_UZ, KEY_LZ: begin secs = 0; ticks = 0; ph = PH_EVAL; return 1; end
        KEY_UA, KEY_LA: if (force_a < 255) force_a++;
        KEY_UB, KEY_LB: if (force_b < 255) force_b++;
        KEY_UC, KEY_LC: begin
          if (force_a < 255) force_a++;
          if (force_b < 255) force_b++;
        end
        default: ;
      endcase
      return 0;
    endfunction

    function void run_phases();
      int unsigned h, l;
      h = hi_reg ? hi_reg : 1;
      l = lo_reg ? lo_reg : 1;
      forever begin
        if (ph == PH_EVAL) begin
          if (force_a) begin force_a--; pa = 1; end
          else pa = (secs == 0) || (mins == 59 && secs >= 10 && secs <= 50 && secs % 2 == 0);
          if (force_b) begin force_b--; pb = 1; end
          else pb = (mins <= 49) && (secs == 0);
          ph = PH_HIGH_WAIT;
        end else if (ph == PH_HIGH_WAIT) begin
          if (ticks < h) return;
          ticks -= h; ph = PH_FALL;
        end else if (ph == PH_FALL) ph = PH_LOW_WAIT;
        else begin
          if (ticks < l) return;
          ticks -= l;
          secs++;
          if (secs > 59) begin secs = 0; mins++; end
          if (mins > 59) mins = 0;
          ph = PH_EVAL;
        end
      end
    endfunction

    function void note_word(bit kind, logic [7:0] c);
      bit chg, bad, is_digit;
      clock_word_t w;
      chg = 0; bad = 0;
      if (!kind) begin
        if (ticks < 255) ticks++;
      end else if (c != 0 && c < 128) begin
        is_digit = (c >= KEY_ZERO && c <= KEY_NINE) || c == KEY_COLON;
        if (is_digit) entering = 1;
        if (entering) chg = entry_char(c, is_digit, bad);
        if (command(c)) chg = 1;
      end
      run_phases();
      w.line_a = (ph == PH_HIGH_WAIT) && pa;
      w.line_b = (ph == PH_HIGH_WAIT) && pb;
      w.minutes = mins; w.seconds = secs;
      w.time_changed = chg; w.bad_time = bad; w.entry_active = entering;
      pending.push_back(w);
    endfunction

    function void check_word(clock_word_t got);
      clock_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word got %p", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (w !== got) begin
        $display("%0t: mismatch expected %p actual %p", $time, w, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we, cfg_addr;
  logic [7:0] cfg_wdata;
  scpg_in_if in_ch();
  scpg_out_if out_ch();

  slave_clock_pulse_generator u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  clock_scoreboard sb;
  bit idle_ok;          // random stalls allowed
  longint cycles;
  int unsigned sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // timeout guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, check every taken word
  initial begin
    int gap;
    out_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (idle_ok && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_word({out_ch.line_a, out_ch.line_b, out_ch.minutes, out_ch.seconds,
                       out_ch.time_changed, out_ch.bad_time, out_ch.entry_active});
    end
  end

  // one word through the input channel, with an optional idle burst first
  task automatic send_word(bit kind, logic [7:0] c);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.kind <= kind;
    in_ch.key_char <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(kind, c);
    sent++;
  endtask

  task automatic send_key(logic [7:0] c);
    send_word(1, c);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_word(0, 8'($urandom));
  endtask

  // wait for all results and let the block go quiet
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] v);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_key(s[i]);
  endtask

  // mostly well-formed entries, some noise and broken ones
  task automatic random_entry();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      case ($urandom_range(0, 9))
        0: send_key(KEY_COLON);
        1: send_key(KEY_BS);
        default: send_key(8'(KEY_ZERO + $urandom_range(0, 9)));
      endcase
    case ($urandom_range(0, 5))
      0: send_key(KEY_ESC);
      1: send_key(KEY_ETX);
      2: send_key(KEY_LZ);
      default: send_key(8'h0d);
    endcase
  endtask

  task automatic random_item();
    logic [7:0] cmds[] = '{KEY_PLUS, KEY_EQ, KEY_MINUS, KEY_UNDER, KEY_UZ, KEY_LZ,
                           KEY_UA, KEY_LA, KEY_UB, KEY_LB, KEY_UC, KEY_LC};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_ticks($urandom_range(1, 12));
      4: random_entry();
      5: send_key(cmds[$urandom_range(0, cmds.size() - 1)]);
      6: send_key(8'($urandom));
      default: send_ticks(1);
    endcase
  endtask

  initial begin
    sb = new();
    sb.errors = 0;
    sb.reset_state();
    idle_ok = 0; sent = 0;
    rst_n = 0; cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    in_ch.valid = 0; in_ch.kind = 0; in_ch.key_char = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: ignored codes, commands, entries, saturation
    send_ticks(3);
    send_key(8'h00); send_key(8'h80); send_key(8'hff);
    send_text("+=-_");
    send_text("59:58\x0d");
    send_ticks(25);
    send_text("12:\x0d");
    send_text(":7\x0d");
    send_text("75\x0d");
    send_text("1234567891\x0d");
    send_text("5\x08\x083\x1b");
    send_text("9\x03");
    send_text("0159z");
    send_text("ABCabc");

    // register extremes
    drain();
    write_reg(CFG_HIGH_TICKS, 8'd1);
    write_reg(CFG_LOW_TICKS, 8'd255);
    send_ticks(300);
    drain();
    write_reg(CFG_HIGH_TICKS, 8'd0);
    write_reg(CFG_LOW_TICKS, 8'd0);
    send_text("C5900\x0d");
    send_ticks(40);
    drain();
    write_reg(CFG_HIGH_TICKS, 8'd255);
    write_reg(CFG_LOW_TICKS, 8'd1);
    send_ticks(20);
    drain();
    // lowered below a grown tick count: several transitions for one word
    write_reg(CFG_HIGH_TICKS, 8'd2);
    write_reg(CFG_LOW_TICKS, 8'd3);

    idle_ok = 1;
    while (sent < 620) random_item();
    drain();      // sender holds off until every result is in
    write_reg(CFG_HIGH_TICKS, 8'($urandom_range(1, 4)));
    write_reg(CFG_LOW_TICKS, 8'($urandom_range(1, 4)));
    while (sent < 760) random_item();
    idle_ok = 0;
    while (sent < 850) random_item();

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/scpg_pkg.sv
hdl/scpg_ifs.sv
hdl/scpg_ctrl.sv
hdl/scpg_dp.sv
hdl/slave_clock_pulse_generator.sv
sim/tb_scpg_ifs.sv
sim/tb_slave_clock_pulse_generator.sv
